// ----- sv/itpc_pkg.sv -----
// Package: shared types and character codes for the IPv4 text parser.
package itpc_pkg;

  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;
  localparam logic [7:0] ChDot  = 8'h2E;

  localparam logic [1:0] MaxDigits   = 2'd3;
  localparam logic [1:0] LastOctet   = 2'd3;
  localparam logic [9:0] OctetMax    = 10'd255;
  localparam logic [7:0] LoopbackNet = 8'd127;
  localparam logic [7:0] MulticastLo = 8'd224;
  localparam logic [7:0] LinkLocalHi = 8'd169;
  localparam logic [7:0] LinkLocalLo = 8'd254;

  typedef struct packed {
    logic [1:0]  octet_index;
    logic [1:0]  digit_count;
    logic [9:0]  octet_value;
    logic        leading_zero;
    logic        parse_failed;
    logic [23:0] committed_octets;
  } parse_state_t;

  typedef struct packed {
    logic        usable;
    logic [31:0] address;
  } parse_result_t;

endpackage

// ----- sv/itpc_if.sv -----
// Interfaces: valid/ready channels for text characters and parse results.
interface itpc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       has_char;
  logic       last;

  modport source (output valid, output ch, output has_char, output last, input ready);
  modport sink   (input valid, input ch, input has_char, input last, output ready);
endinterface

interface itpc_out_if;
  logic        valid;
  logic        ready;
  logic        usable;
  logic [31:0] address;

  modport source (output valid, output usable, output address, input ready);
  modport sink   (input valid, input usable, input address, output ready);
endinterface

// ----- sv/itpc_step.sv -----
// Per-character parse step: next state and end-of-text result.
module itpc_step (
  input  itpc_pkg::parse_state_t  state,
  input  logic [7:0]              ch,
  input  logic                    has_char,
  input  logic                    last,
  output itpc_pkg::parse_state_t  state_next,
  output itpc_pkg::parse_result_t result
);

  itpc_pkg::parse_state_t st;
  logic        is_digit;
  logic        is_dot;
  logic [3:0]  digit;
  logic [13:0] times_ten;
  logic        cur_ok;
  logic        end_ok;
  logic [31:0] addr;

  assign is_digit  = (ch >= itpc_pkg::ChZero) && (ch <= itpc_pkg::ChNine);
  assign is_dot    = (ch == itpc_pkg::ChDot);
  assign digit     = ch[3:0];
  assign times_ten = {1'b0, state.octet_value, 3'b000} + {3'b000, state.octet_value, 1'b0}
                   + {10'd0, digit};
  assign cur_ok    = (state.digit_count != 2'd0) && (state.octet_value <= itpc_pkg::OctetMax)
                   && !((state.digit_count > 2'd1) && state.leading_zero);

  always_comb begin
    st = state;
    if (has_char && !state.parse_failed) begin
      if (is_digit) begin
        if (state.digit_count == itpc_pkg::MaxDigits) begin
          st.parse_failed = 1'b1;
        end else begin
          if (state.digit_count == 2'd0 && digit == 4'd0) st.leading_zero = 1'b1;
          st.octet_value = times_ten[9:0];
          st.digit_count = state.digit_count + 2'd1;
        end
      end else if (is_dot) begin
        if (!cur_ok || state.octet_index == itpc_pkg::LastOctet) begin
          st.parse_failed = 1'b1;
        end else begin
          st.committed_octets = {state.committed_octets[15:0], state.octet_value[7:0]};
          st.octet_index      = state.octet_index + 2'd1;
          st.digit_count      = 2'd0;
          st.octet_value      = 10'd0;
          st.leading_zero     = 1'b0;
        end
      end else begin
        st.parse_failed = 1'b1;
      end
    end
  end

  // checks on the state after this character
  always_comb begin
    addr   = {st.committed_octets, st.octet_value[7:0]};
    end_ok = !st.parse_failed && (st.octet_index == itpc_pkg::LastOctet)
           && (st.digit_count != 2'd0) && (st.octet_value <= itpc_pkg::OctetMax)
           && !((st.digit_count > 2'd1) && st.leading_zero);
    if (addr[31:24] == 8'd0 || addr[31:24] == itpc_pkg::LoopbackNet
        || addr[31:24] >= itpc_pkg::MulticastLo) end_ok = 1'b0;
    if (addr[31:24] == itpc_pkg::LinkLocalHi && addr[23:16] == itpc_pkg::LinkLocalLo)
      end_ok = 1'b0;
    result.usable  = end_ok;
    result.address = end_ok ? addr : 32'd0;
    state_next     = last ? '0 : st;
  end

endmodule

// ----- sv/ipv4_text_parse_check.sv -----
// Top level: strict dotted-decimal IPv4 text parser with usability check.
// A beat carrying last passes the input register, then the result register, and is held
// in the input register while a pending result is not taken. Throughput: one character beat
// per cycle otherwise; the parse step is combinational between the input and result registers.
// A pending result does not block input beats that carry no last mark.
// Reset (rst, synchronous) clears the parse state and both valid flags.
module ipv4_text_parse_check (
  input  logic              clk,
  input  logic              rst,
  itpc_in_if.sink           text,
  itpc_out_if.source        result
);

  logic       v1;
  logic [7:0] ch1;
  logic       has1;
  logic       last1;

  itpc_pkg::parse_state_t  state;
  itpc_pkg::parse_state_t  state_next;
  itpc_pkg::parse_result_t step_res;
  itpc_pkg::parse_result_t res;
  logic                    out_valid;

  logic out_free;
  logic proc;

  assign out_free   = !out_valid || result.ready;
  assign proc       = v1 && (!last1 || out_free);
  assign text.ready = !v1 || proc;

  itpc_step u_step (
    .state      (state),
    .ch         (ch1),
    .has_char   (has1),
    .last       (last1),
    .state_next (state_next),
    .result     (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (text.ready) begin
      v1 <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.ready && text.valid) begin
      ch1   <= text.ch;
      has1  <= text.has_char;
      last1 <= text.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (proc) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc && last1) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && last1) begin
      res <= step_res;
    end
  end

  assign result.valid   = out_valid;
  assign result.usable  = res.usable;
  assign result.address = res.address;

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    proc && last1 |=> state == '0)
    else $error("parse state not cleared after end of text");

  a_stall_reason: assert property (@(posedge clk) disable iff (rst)
    !text.ready |-> v1 && last1 && out_valid && !result.ready)
    else $error("input stalled without a blocked result");

  a_unusable_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !res.usable |-> res.address == 32'd0)
    else $error("unusable result carries an address");

  a_usable_first: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.usable |-> res.address[31:24] != 8'd0
                             && res.address[31:24] != itpc_pkg::LoopbackNet
                             && res.address[31:24] < itpc_pkg::MulticastLo)
    else $error("usable result in a reserved first-octet range");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    proc && last1 |=> out_valid)
    else $error("end of text produced no result beat");

endmodule

// ----- dv/ipv4_text_parse_check_test.sv -----
// Testbench for the IPv4 text parser: directed and random address texts checked beat by beat.
module ipv4_text_parse_check_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BeatTarget   = 1400;
  localparam int unsigned MaxWait      = 11;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned ReportLimit  = 10;
  localparam int unsigned SettleCycles = 8;

  typedef struct {
    logic [7:0]  ch;
    logic        has_char;
    logic        last;
    int unsigned gap;
    bit          hold;
  } text_beat_t;

  logic clk = 1'b0;
  logic rst;

  itpc_in_if  text_if ();
  itpc_out_if res_if ();

  ipv4_text_parse_check u_top (
    .clk    (clk),
    .rst    (rst),
    .text   (text_if),
    .result (res_if)
  );

  text_beat_t              text_beats[$];
  itpc_pkg::parse_result_t expected_verdicts[$];
  logic [7:0]              text_buf[$];
  itpc_pkg::parse_state_t  scan;

  logic        in_fire;
  logic        out_fire;
  bit          src_calm;
  bit          sink_calm;
  int unsigned gap_count;
  int unsigned sink_wait;
  int unsigned sink_phase;
  int unsigned quiet_cycles;
  int unsigned fail_count;
  int unsigned char_beats;
  int unsigned texts_sent;
  int unsigned verdicts_seen;
  int unsigned usable_seen;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic octet_complete(itpc_pkg::parse_state_t s);
    return s.digit_count != 2'd0 && s.octet_value <= itpc_pkg::OctetMax &&
           !(s.digit_count > 2'd1 && s.leading_zero);
  endfunction

  function automatic void scan_char(logic [7:0] c);
    if (scan.parse_failed) return;
    if (c >= itpc_pkg::ChZero && c <= itpc_pkg::ChNine) begin
      if (scan.digit_count >= itpc_pkg::MaxDigits) begin
        scan.parse_failed = 1'b1;
      end else begin
        if (scan.digit_count == 2'd0 && c == itpc_pkg::ChZero) scan.leading_zero = 1'b1;
        scan.octet_value = scan.octet_value * 10'd10 + {2'b00, c - itpc_pkg::ChZero};
        scan.digit_count = scan.digit_count + 2'd1;
      end
    end else if (c == itpc_pkg::ChDot) begin
      if (!octet_complete(scan) || scan.octet_index >= itpc_pkg::LastOctet) begin
        scan.parse_failed = 1'b1;
      end else begin
        scan.committed_octets = {scan.committed_octets[15:0], scan.octet_value[7:0]};
        scan.octet_index      = scan.octet_index + 2'd1;
        scan.digit_count      = 2'd0;
        scan.octet_value      = 10'd0;
        scan.leading_zero     = 1'b0;
      end
    end else begin
      scan.parse_failed = 1'b1;
    end
  endfunction

  function automatic itpc_pkg::parse_result_t close_text();
    itpc_pkg::parse_result_t r;
    logic [31:0]             addr;
    logic                    ok;
    ok   = !scan.parse_failed && scan.octet_index == itpc_pkg::LastOctet &&
           octet_complete(scan);
    addr = {scan.committed_octets, scan.octet_value[7:0]};
    if (addr[31:24] == 8'd0 || addr[31:24] == itpc_pkg::LoopbackNet ||
        addr[31:24] >= itpc_pkg::MulticastLo)
      ok = 1'b0;
    if (addr[31:24] == itpc_pkg::LinkLocalHi && addr[23:16] == itpc_pkg::LinkLocalLo)
      ok = 1'b0;
    r.usable  = ok;
    r.address = ok ? addr : 32'd0;
    scan = '0;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void push_beat(logic [7:0] c, logic has, logic fin, bit hold);
    text_beat_t b;
    b.ch       = c;
    b.has_char = has;
    b.last     = fin;
    b.gap      = src_calm ? 0 : $urandom_range(0, MaxWait);
    b.hold     = hold;
    text_beats.push_back(b);
    if (has || fin) char_beats++;
  endfunction

  // hold makes the first beat wait until all outstanding results are back
  function automatic void queue_text(bit empty_end, bit hold);
    bit first;
    first = hold;
    foreach (text_buf[i]) begin
      if ($urandom_range(0, 19) == 0) begin
        push_beat(8'($urandom), 1'b0, 1'b0, first);
        first = 1'b0;
      end
      push_beat(text_buf[i], 1'b1, (i == text_buf.size() - 1) && !empty_end, first);
      first = 1'b0;
    end
    if (empty_end || text_buf.size() == 0) push_beat(8'($urandom), 1'b0, 1'b1, first);
    texts_sent++;
  endfunction

  function automatic void append_string(string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endfunction

  function automatic void load_string(string s);
    text_buf.delete();
    append_string(s);
  endfunction

  function automatic int unsigned random_octet();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 9);
      1: return $urandom_range(10, 99);
      2: return 255;
      3: return 0;
      default: return $urandom_range(100, 255);
    endcase
  endfunction

  function automatic void load_address();
    int unsigned o[4];
    foreach (o[i]) o[i] = random_octet();
    case ($urandom_range(0, 11))
      0: o[0] = 0;
      1: o[0] = itpc_pkg::LoopbackNet;
      2: begin
        o[0] = itpc_pkg::LinkLocalHi;
        if ($urandom_range(0, 1) == 1) o[1] = itpc_pkg::LinkLocalLo;
      end
      3: o[0] = $urandom_range(itpc_pkg::MulticastLo, 255);
      4: o[0] = itpc_pkg::MulticastLo - 1;
      default: ;
    endcase
    load_string($sformatf("%0d.%0d.%0d.%0d", o[0], o[1], o[2], o[3]));
  endfunction

  // one random edit on a well-formed address, most often a syntax fault
  function automatic void mangle_text();
    int unsigned pos;
    int unsigned starts[$];
    pos = $urandom_range(0, text_buf.size() - 1);
    case ($urandom_range(0, 7))
      0: text_buf[pos] = 8'($urandom);
      1: begin
        starts.push_back(0);
        foreach (text_buf[i]) if (text_buf[i] == itpc_pkg::ChDot) starts.push_back(i + 1);
        text_buf.insert(starts[$urandom_range(0, starts.size() - 1)], itpc_pkg::ChZero);
      end
      2: text_buf.delete(pos);
      3: text_buf.insert(pos, itpc_pkg::ChDot);
      4: repeat ($urandom_range(1, 2))
           text_buf.push_back(itpc_pkg::ChZero + 8'($urandom_range(0, 9)));
      5: begin
        while (text_buf.size() != 0 && text_buf[$] != itpc_pkg::ChDot)
          void'(text_buf.pop_back());
        append_string($sformatf("%0d", $urandom_range(256, 999)));
      end
      6: begin
        while (text_buf.size() != 0 && text_buf[$] != itpc_pkg::ChDot)
          void'(text_buf.pop_back());
        if ($urandom_range(0, 1) == 1) void'(text_buf.pop_back());
      end
      default: append_string($sformatf(".%0d", random_octet()));
    endcase
  endfunction

  function automatic void load_noise();
    text_buf.delete();
    repeat ($urandom_range(0, 10)) begin
      case ($urandom_range(0, 9))
        0, 1: text_buf.push_back(itpc_pkg::ChDot);
        2, 3, 4: text_buf.push_back(8'($urandom));
        default: text_buf.push_back(itpc_pkg::ChZero + 8'($urandom_range(0, 9)));
      endcase
    end
  endfunction

  // ---------------------------------------------------------------- drivers

  always @(negedge clk) begin
    text_beat_t nxt;
    if (rst) begin
      text_if.valid    <= 1'b0;
      text_if.ch       <= 8'h00;
      text_if.has_char <= 1'b0;
      text_if.last     <= 1'b0;
      gap_count = 0;
    end else if (!text_if.valid || in_fire) begin
      if (text_beats.size() == 0) begin
        text_if.valid <= 1'b0;
      end else if (gap_count < text_beats[0].gap ||
                   (text_beats[0].hold && expected_verdicts.size() != 0)) begin
        text_if.valid <= 1'b0;
        gap_count++;
      end else begin
        nxt = text_beats.pop_front();
        text_if.valid    <= 1'b1;
        text_if.ch       <= nxt.ch;
        text_if.has_char <= nxt.has_char;
        text_if.last     <= nxt.last;
        gap_count = 0;
      end
    end
  end

  // result side: stall per beat, alternating with stretches of steady ready
  always @(negedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
      sink_wait  = $urandom_range(0, MaxWait);
      sink_phase = 0;
    end else begin
      if (sink_phase == 0) begin
        sink_calm  = ($urandom_range(0, 2) == 0);
        sink_phase = $urandom_range(20, 200);
      end else begin
        sink_phase--;
      end
      if (out_fire) sink_wait = sink_calm ? 0 : $urandom_range(0, MaxWait);
      if (sink_wait != 0 && res_if.valid) begin
        res_if.ready <= 1'b0;
        sink_wait--;
      end else begin
        res_if.ready <= (sink_wait == 0);
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  function automatic void report_failure(string msg);
    fail_count++;
    if (fail_count <= ReportLimit) $display("%0t: %s", $time, msg);
  endfunction

  always @(posedge clk) begin
    itpc_pkg::parse_result_t want;
    if (rst) begin
      in_fire  <= 1'b0;
      out_fire <= 1'b0;
      scan = '0;
    end else begin
      in_fire  <= text_if.valid && text_if.ready;
      out_fire <= res_if.valid && res_if.ready;
      // compare first: a result can never belong to a text closed this cycle
      if (res_if.valid && res_if.ready) begin
        verdicts_seen++;
        if (expected_verdicts.size() == 0) begin
          report_failure($sformatf("result %0d not expected: usable=%0b address=%h",
                                   verdicts_seen, res_if.usable, res_if.address));
        end else begin
          want = expected_verdicts.pop_front();
          if (res_if.usable !== want.usable)
            report_failure($sformatf("result %0d usable: expected %0b, got %0b",
                                     verdicts_seen, want.usable, res_if.usable));
          if (res_if.address !== want.address)
            report_failure($sformatf("result %0d address: expected %h, got %h",
                                     verdicts_seen, want.address, res_if.address));
          if (want.usable) usable_seen++;
        end
      end
      if (text_if.valid && text_if.ready) begin
        if (text_if.has_char) scan_char(text_if.ch);
        if (text_if.last) expected_verdicts.push_back(close_text());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || in_fire || out_fire) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == StallLimit) begin
        $display("watchdog: %0d cycles with no beat on either side", StallLimit);
        $display("ipv4_text_parse_check regression: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    string       directed_texts[$] = '{"", "1.2.3.4", "223.255.255.254", "255.255.255.255",
                                       "0.1.2.3", "127.0.0.1", "224.0.0.1", "169.254.1.1",
                                       "169.253.1.1", "1.2.3.256", "1.256.3.4", "999.1.1.1",
                                       "01.2.3.4", "1.2.3.00", "10.0.0.0", "1.2.3.1234",
                                       ".1.2.3", "1..2.3", "1.2.3.4.", "1.2.3", "1.2.3.",
                                       "1.2.a.4", "1x2.3.4", "9.8.7.6"};
    int unsigned pick;

    rst              = 1'b1;
    text_if.valid    = 1'b0;
    text_if.ch       = 8'h00;
    text_if.has_char = 1'b0;
    text_if.last     = 1'b0;
    res_if.ready     = 1'b0;

    // directed texts; the loopback one also waits for the pipe to drain
    foreach (directed_texts[k]) begin
      load_string(directed_texts[k]);
      queue_text(k % 3 == 1, k == 5);
    end
    push_beat(8'hA5, 1'b0, 1'b0, 1'b0);
    load_string("1.2.3.4");
    text_buf.push_back(8'h00);
    queue_text(1'b0, 1'b0);
    load_string("8.8.8.8");
    text_buf.insert(3, 8'hFF);
    queue_text(1'b1, 1'b0);

    while (char_beats < BeatTarget) begin
      if ($urandom_range(0, 15) == 0) src_calm = !src_calm;
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
        load_address();
      end else if (pick < 17) begin
        load_address();
        mangle_text();
      end else begin
        load_noise();
      end
      queue_text($urandom_range(0, 3) == 0, $urandom_range(0, 59) == 0);
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (text_beats.size() != 0 || text_if.valid) @(posedge clk);
    @(negedge clk);
    while (expected_verdicts.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);

    $display("covered %0d address texts over %0d counted beats", texts_sent, char_beats);
    $display("checked %0d results, %0d of them usable", verdicts_seen, usable_seen);
    if (fail_count == 0) begin
      $display("ipv4_text_parse_check regression: pass");
    end else begin
      $display("%0d failures", fail_count);
      $display("ipv4_text_parse_check regression: fail");
    end
    $finish;
  end

endmodule
